// File: hdl/twrtc_pkg.sv
// shared types, codes and small functions for the three-wire rtc time master
// no dependencies; the sequencer, result register and top module import this package

package twrtc_pkg;

   // operation codes carried by an input item
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SET  = 2'd1,
      OP_GET  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_PRE  = 4'd1,
      PH_EN   = 4'd2,
      PH_ALO  = 4'd3,
      PH_AHI  = 4'd4,
      PH_DLO  = 4'd5,
      PH_DHI  = 4'd6,
      PH_RHI  = 4'd7,
      PH_RLO  = 4'd8
   } phase_type;

   // transfer numbering: set time uses 0..4, get time uses 5..7
   localparam logic [2:0] XFER_SET_FIRST = 3'd0;
   localparam logic [2:0] XFER_SET_LAST  = 3'd4;
   localparam logic [2:0] XFER_GET_FIRST = 3'd5;
   localparam logic [2:0] XFER_GET_LAST  = 3'd7;

   // register addresses and write-protect values
   localparam logic [7:0] ADDR_CTRL_WR  = 8'h8E;
   localparam logic [7:0] ADDR_HOUR_WR  = 8'h84;
   localparam logic [7:0] ADDR_MIN_WR   = 8'h82;
   localparam logic [7:0] ADDR_SEC_WR   = 8'h80;
   localparam logic [7:0] ADDR_HOUR_RD  = 8'h85;
   localparam logic [7:0] ADDR_MIN_RD   = 8'h83;
   localparam logic [7:0] ADDR_SEC_RD   = 8'h81;
   localparam logic [7:0] WP_OFF        = 8'h00;
   localparam logic [7:0] WP_ON         = 8'h80;
   localparam logic [3:0] NIBBLE_MASK   = 4'hF;

   // one input item
   typedef struct packed {
      logic [1:0] operation;
      logic [4:0] set_hours;
      logic [5:0] set_minutes;
      logic [5:0] set_seconds;
      logic       data_pin_in;
   } twrtc_item_type;

   // pin levels and status of one result
   typedef struct packed {
      logic enable;
      logic sclk;
      logic data;
      logic busy;
      logic time_valid;
   } twrtc_pins_type;

   // address byte of each transfer
   function automatic logic [7:0] xfer_addr(input logic [2:0] t);
      logic [7:0] a;
      case (t)
         3'd0:    a = ADDR_CTRL_WR;
         3'd1:    a = ADDR_HOUR_WR;
         3'd2:    a = ADDR_MIN_WR;
         3'd3:    a = ADDR_SEC_WR;
         3'd4:    a = ADDR_CTRL_WR;
         3'd5:    a = ADDR_HOUR_RD;
         3'd6:    a = ADDR_MIN_RD;
         default: a = ADDR_SEC_RD;
      endcase
      return a;
   endfunction

   // length of each phase in microsecond ticks
   function automatic logic [2:0] phase_len(input phase_type p);
      logic [2:0] n;
      case (p)
         PH_PRE:  n = 3'd5;
         PH_EN:   n = 3'd1;
         PH_ALO:  n = 3'd2;
         PH_AHI:  n = 3'd5;
         PH_DLO:  n = 3'd2;
         PH_DHI:  n = 3'd5;
         PH_RHI:  n = 3'd3;
         PH_RLO:  n = 3'd2;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

   // binary to bcd for values below 64, divide by ten via multiply by 205/2048
   function automatic logic [7:0] to_bcd(input logic [5:0] v);
      logic [13:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens10;
      logic [3:0]  ones;
      prod   = 14'(v) * 14'd205;
      tens   = {1'b0, prod[13:11]};
      tens10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      ones   = 4'(7'(v) - tens10);
      return {tens, ones & NIBBLE_MASK};
   endfunction

   // bcd to binary without masking the flag bits
   function automatic logic [7:0] from_bcd(input logic [7:0] b);
      return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
   endfunction

endpackage

// File: hdl/twrtc_req_if.sv
// input item channel: valid/ready handshake with the item fields
// depends on nothing

interface twrtc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [4:0] set_hours;
   logic [5:0] set_minutes;
   logic [5:0] set_seconds;
   logic       data_pin_in;

   modport source (output valid, operation, set_hours, set_minutes, set_seconds,
                   data_pin_in, input ready);
   modport sink   (input valid, operation, set_hours, set_minutes, set_seconds,
                   data_pin_in, output ready);
endinterface

// File: hdl/twrtc_rsp_if.sv
// result item channel: valid/ready handshake with the result fields
// depends on nothing

interface twrtc_rsp_if;
   logic       valid;
   logic       ready;
   logic       enable_pin;
   logic       clock_pin;
   logic       data_pin_out;
   logic       busy_res;
   logic       time_valid;
   logic [7:0] read_hours;
   logic [7:0] read_minutes;
   logic [7:0] read_seconds;

   modport source (output valid, enable_pin, clock_pin, data_pin_out, busy_res,
                   time_valid, read_hours, read_minutes, read_seconds, input ready);
   modport sink   (input valid, enable_pin, clock_pin, data_pin_out, busy_res,
                   time_valid, read_hours, read_minutes, read_seconds, output ready);
endinterface

// File: hdl/three_wire_rtc_time_master.sv
// Three-wire serial master for a real-time clock: each item is a one-microsecond
// tick (carrying the sampled data pin) or a set-time / get-time command, and each
// item gives exactly one result with the pin levels, busy flag and the decoded
// last captured hour, minute and second. One item is taken every cycle; its
// result appears in the result register on the following cycle. The sequencer
// state is updated in the same cycle an item is taken, so throughput is set only
// by the single-entry result register, which stalls input while it is full and
// not being drained. A set time takes 5 transfers of 6 + 16*7 ticks each, a get
// time 3 transfers of 6 + 8*7 + 8*5 ticks; commands while busy are ignored.
// depends on twrtc_pkg, twrtc_req_if, twrtc_rsp_if, twrtc_seq, twrtc_rsp

module three_wire_rtc_time_master import twrtc_pkg::*; (
   input logic        clock,
   input logic        reset,
   twrtc_req_if.sink  req_ch,
   twrtc_rsp_if.source rsp_ch
);

   logic           accept;
   logic           in_ready;
   twrtc_item_type item;
   twrtc_pins_type pins;
   twrtc_pins_type out_pins;
   logic [7:0]     captured_next [3];

   assign item.operation   = req_ch.operation;
   assign item.set_hours   = req_ch.set_hours;
   assign item.set_minutes = req_ch.set_minutes;
   assign item.set_seconds = req_ch.set_seconds;
   assign item.data_pin_in = req_ch.data_pin_in;

   assign req_ch.ready = in_ready;
   assign accept       = req_ch.valid && in_ready;

   // sequencer
   twrtc_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .item          (item),
      .pins          (pins),
      .captured_next (captured_next)
   );

   // result register
   twrtc_rsp u_rsp (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .out_ready     (rsp_ch.ready),
      .pins          (pins),
      .captured_next (captured_next),
      .in_ready      (in_ready),
      .out_valid     (rsp_ch.valid),
      .out_pins      (out_pins),
      .out_hours     (rsp_ch.read_hours),
      .out_minutes   (rsp_ch.read_minutes),
      .out_seconds   (rsp_ch.read_seconds)
   );

   assign rsp_ch.enable_pin   = out_pins.enable;
   assign rsp_ch.clock_pin    = out_pins.sclk;
   assign rsp_ch.data_pin_out = out_pins.data;
   assign rsp_ch.busy_res     = out_pins.busy;
   assign rsp_ch.time_valid   = out_pins.time_valid;

`ifndef ASSERT_OFF
   // an accepted item always shows up as a result next cycle
   a_item_to_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ch.valid)
      else $error("accepted item did not produce a result");

   // a finished get time leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.time_valid) |-> !rsp_ch.busy_res)
      else $error("time_valid while still busy");

   // the serial clock only toggles with chip enable raised
   a_clock_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.clock_pin) |-> rsp_ch.enable_pin)
      else $error("serial clock high with enable low");
`endif

endmodule

// File: hdl/twrtc_seq.sv
// transfer sequencer: phase, timing, shift and captured time registers
// depends on twrtc_pkg

module twrtc_seq import twrtc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  twrtc_item_type item,
   output twrtc_pins_type pins,
   output logic [7:0]     captured_next [3]
);

   phase_type  phase_ff, phase_in;
   logic [2:0] delay_ff, delay_in;
   logic [2:0] bit_ff, bit_in;
   logic [2:0] xfer_ff, xfer_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] pending_ff [3];
   logic [7:0] pending_in [3];
   logic [7:0] captured_ff [3];
   logic [7:0] captured_in [3];

   op_type     op;
   logic [2:0] delay_inc;
   logic       phase_done;
   logic       xfer_end;
   logic       get_done;
   logic       cur_bit;
   logic [7:0] wr_data;
   logic [2:0] cap_sel;

   assign op        = op_type'(item.operation);
   assign delay_inc = delay_ff + 3'd1;
   assign phase_done = (delay_inc >= phase_len(phase_ff));
   assign cur_bit   = shift_ff[bit_ff];
   assign cap_sel   = xfer_ff - XFER_GET_FIRST;

   // data byte of a write transfer
   always_comb begin
      case (xfer_ff)
         3'd1:    wr_data = pending_ff[0];
         3'd2:    wr_data = pending_ff[1];
         3'd3:    wr_data = pending_ff[2];
         3'd4:    wr_data = WP_ON;
         default: wr_data = WP_OFF;
      endcase
   end

   // pin levels of the current position, busy and done status after the item
   always_comb begin
      pins.enable     = 1'b1;
      pins.sclk       = 1'b0;
      pins.data       = 1'b0;
      pins.busy       = (phase_in != PH_IDLE);
      pins.time_valid = get_done;
      case (phase_ff)
         PH_PRE: pins.enable = 1'b0;
         PH_EN: ;
         PH_ALO, PH_DLO: pins.data = cur_bit;
         PH_AHI, PH_DHI: begin
            pins.sclk = 1'b1;
            pins.data = cur_bit;
         end
         PH_RHI: begin
            pins.sclk = 1'b1;
            pins.data = 1'b1;
         end
         PH_RLO: pins.data = 1'b1;
         default: pins.enable = 1'b0;
      endcase
   end

   // next state of the sequencer
   always_comb begin
      phase_in    = phase_ff;
      delay_in    = delay_ff;
      bit_in      = bit_ff;
      xfer_in     = xfer_ff;
      shift_in    = shift_ff;
      pending_in  = pending_ff;
      captured_in = captured_ff;
      xfer_end    = 1'b0;
      get_done    = 1'b0;
      case (op)
         OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               // sample the data pin at the end of the second low tick
               if (phase_ff == PH_RLO && delay_ff == 3'd1) begin
                  shift_in = {item.data_pin_in, shift_ff[7:1]};
               end
               delay_in = delay_inc;
               if (phase_done) begin
                  delay_in = 3'd0;
                  case (phase_ff)
                     PH_PRE: phase_in = PH_EN;
                     PH_EN: begin
                        phase_in = PH_ALO;
                        bit_in   = 3'd0;
                     end
                     PH_ALO: phase_in = PH_AHI;
                     PH_DLO: phase_in = PH_DHI;
                     PH_RHI: phase_in = PH_RLO;
                     PH_AHI: begin
                        if (bit_ff != 3'd7) begin
                           bit_in   = bit_ff + 3'd1;
                           phase_in = PH_ALO;
                        end else begin
                           bit_in = 3'd0;
                           if (xfer_ff >= XFER_GET_FIRST) begin
                              shift_in = 8'h00;
                              phase_in = PH_RHI;
                           end else begin
                              shift_in = wr_data;
                              phase_in = PH_DLO;
                           end
                        end
                     end
                     PH_DHI: begin
                        if (bit_ff != 3'd7) begin
                           bit_in   = bit_ff + 3'd1;
                           phase_in = PH_DLO;
                        end else begin
                           xfer_end = 1'b1;
                        end
                     end
                     PH_RLO: begin
                        if (bit_ff != 3'd7) begin
                           bit_in   = bit_ff + 3'd1;
                           phase_in = PH_RHI;
                        end else begin
                           xfer_end = 1'b1;
                        end
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
         end
         OP_SET: begin
            if (phase_ff == PH_IDLE) begin
               pending_in[0] = to_bcd({1'b0, item.set_hours});
               pending_in[1] = to_bcd(item.set_minutes);
               pending_in[2] = to_bcd(item.set_seconds);
               xfer_in  = XFER_SET_FIRST;
               phase_in = PH_PRE;
               delay_in = 3'd0;
               bit_in   = 3'd0;
               shift_in = xfer_addr(XFER_SET_FIRST);
            end
         end
         OP_GET: begin
            if (phase_ff == PH_IDLE) begin
               xfer_in  = XFER_GET_FIRST;
               phase_in = PH_PRE;
               delay_in = 3'd0;
               bit_in   = 3'd0;
               shift_in = xfer_addr(XFER_GET_FIRST);
            end
         end
         default: ;
      endcase

      // end of a transfer: store a read byte, chain the next or go idle
      if (xfer_end) begin
         if (xfer_ff >= XFER_GET_FIRST) begin
            captured_in[cap_sel[1:0]] = shift_in;
         end
         if (xfer_ff == XFER_GET_LAST || xfer_ff == XFER_SET_LAST) begin
            phase_in = PH_IDLE;
            xfer_in  = 3'd0;
            get_done = (xfer_ff == XFER_GET_LAST);
         end else begin
            xfer_in  = xfer_ff + 3'd1;
            phase_in = PH_PRE;
            delay_in = 3'd0;
            bit_in   = 3'd0;
            shift_in = xfer_addr(xfer_ff + 3'd1);
         end
      end
   end

   assign captured_next = captured_in;

   // state registers, advanced once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         delay_ff    <= 3'd0;
         bit_ff      <= 3'd0;
         xfer_ff     <= 3'd0;
         shift_ff    <= 8'h00;
         pending_ff  <= '{default: 8'h00};
         captured_ff <= '{default: 8'h00};
      end else if (accept) begin
         phase_ff    <= phase_in;
         delay_ff    <= delay_in;
         bit_ff      <= bit_in;
         xfer_ff     <= xfer_in;
         shift_ff    <= shift_in;
         pending_ff  <= pending_in;
         captured_ff <= captured_in;
      end
   end

endmodule

// File: hdl/twrtc_rsp.sv
// result register: holds one result item until taken, decodes the captured time
// depends on twrtc_pkg

module twrtc_rsp import twrtc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic           out_ready,
   input  twrtc_pins_type pins,
   input  logic [7:0]     captured_next [3],
   output logic           in_ready,
   output logic           out_valid,
   output twrtc_pins_type out_pins,
   output logic [7:0]     out_hours,
   output logic [7:0]     out_minutes,
   output logic [7:0]     out_seconds
);

   logic           valid_ff, valid_in;
   twrtc_pins_type pins_ff;
   logic [7:0]     hours_ff, minutes_ff, seconds_ff;

   // free when empty or being drained this cycle
   assign in_ready = !valid_ff || out_ready;

   // valid flag
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, loaded on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         pins_ff    <= pins;
         hours_ff   <= from_bcd(captured_next[0]);
         minutes_ff <= from_bcd(captured_next[1]);
         seconds_ff <= from_bcd(captured_next[2]);
      end
   end

   assign out_valid   = valid_ff;
   assign out_pins    = pins_ff;
   assign out_hours   = hours_ff;
   assign out_minutes = minutes_ff;
   assign out_seconds = seconds_ff;

endmodule
